// ===== sv/windowed_latency_percentiles_top_defines.svh =====
// ----------------------------------------------------------------------------
// windowed_latency_percentiles_top_defines
// Assertion macros shared by the latency monitor RTL.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_LATENCY_PERCENTILES_TOP_DEFINES_SVH
`define WINDOWED_LATENCY_PERCENTILES_TOP_DEFINES_SVH

// same-cycle implication
`define WLP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wlp assertion failed");

// next-cycle implication
`define WLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wlp assertion failed");

`endif

// ===== sv/wlp_pkg.sv =====
// ----------------------------------------------------------------------------
// wlp_pkg
// Types and constants of the windowed latency percentile monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package wlp_pkg;

   localparam int DUR_W        = 48;
   localparam int TIME_W       = 64;
   localparam int CNT_W        = 11;
   localparam int MEAN_W       = 56;
   localparam int FRAC_W       = 8;
   localparam int ENTRY_W      = DUR_W + TIME_W;
   localparam int BIT_W        = $clog2(DUR_W);
   localparam int DEF_CAPACITY = 1024;
   localparam int REQ_TDATA_W  = 176;
   localparam int RSP_TDATA_W  = 312;

   localparam logic [TIME_W-1:0] MAX_AGE_RESET = 64'd1000000;
   localparam logic [CNT_W-1:0]  P999_RESET    = 11'd1000;

   typedef enum logic {
      OP_RECORD = 1'b0,
      OP_QUERY  = 1'b1
   } wlp_op_type;

   typedef enum logic {
      CSR_MAX_AGE  = 1'b0,
      CSR_P999_MIN = 1'b1
   } wlp_csr_type;

   typedef struct packed {
      logic              pct999_valid;
      logic [DUR_W-1:0]  largest;
      logic [DUR_W-1:0]  pct999;
      logic [DUR_W-1:0]  pct99;
      logic [DUR_W-1:0]  pct95;
      logic [DUR_W-1:0]  median;
      logic [MEAN_W-1:0] mean_fixed;
      logic [CNT_W-1:0]  sample_count;
   } wlp_result_type;

endpackage

`default_nettype wire

// ===== sv/wlp_store.sv =====
// ----------------------------------------------------------------------------
// wlp_store
// Sample ring memory: {completed_at, duration} per entry, one write port,
// one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module wlp_store #(
   parameter int CAPACITY = wlp_pkg::DEF_CAPACITY,
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  wire logic                       clock,
   input  wire logic                       we,
   input  wire logic [AW-1:0]              waddr,
   input  wire logic [wlp_pkg::ENTRY_W-1:0] wdata,
   input  wire logic                       re,
   input  wire logic [AW-1:0]              raddr,
   output logic      [wlp_pkg::ENTRY_W-1:0] rdata
);
   import wlp_pkg::*;

   logic [ENTRY_W-1:0] mem [CAPACITY];
   logic [ENTRY_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== sv/wlp_div.sv =====
// ----------------------------------------------------------------------------
// wlp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wlp_div #(
   parameter int DW = 66,
   parameter int VW = 11
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [VW-1:0] divisor,
   output logic               done,
   output logic      [DW-1:0] quotient
);
   localparam int CTW = $clog2(DW + 1);

   logic           busy_ff;
   logic           done_ff;
   logic [CTW-1:0] cnt_ff;
   logic [DW-1:0]  q_ff;
   logic [VW-1:0]  r_ff;
   logic [VW-1:0]  dv_ff;
   logic [VW:0]    trial;
   logic           fits;

   assign trial = {r_ff, q_ff[DW-1]};
   assign fits  = trial >= {1'b0, dv_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CTW'(DW);
            q_ff    <= dividend;
            r_ff    <= '0;
            dv_ff   <= divisor;
         end else if (busy_ff) begin
            r_ff   <= fits ? VW'(trial - {1'b0, dv_ff}) : trial[VW-1:0];
            q_ff   <= {q_ff[DW-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CTW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

// ===== sv/wlp_query.sv =====
// ----------------------------------------------------------------------------
// wlp_query
// Query sequencer: one summing pass over the ring, rank products and the mean
// division, then one counting pass per duration bit to select the four
// percentiles.
// ----------------------------------------------------------------------------
`default_nettype none

module wlp_query #(
   parameter int CAPACITY = wlp_pkg::DEF_CAPACITY,
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [wlp_pkg::TIME_W-1:0]  now_time,
   input  wire logic [wlp_pkg::TIME_W-1:0]  max_age,
   input  wire logic [wlp_pkg::CNT_W-1:0]   p999_min,
   input  wire logic [CW-1:0]               fill,
   output logic                             mem_re,
   output logic      [AW-1:0]               mem_raddr,
   input  wire logic [wlp_pkg::ENTRY_W-1:0] mem_rdata,
   input  wire logic                        take,
   output logic                             done,
   output wlp_pkg::wlp_result_type          result
);
   import wlp_pkg::*;

   localparam int VW   = (CW > 10) ? CW : 10;
   localparam int SW   = DUR_W + CW;
   localparam int DW   = SW + FRAC_W;
   localparam int NUMW = CW + 10;
   localparam int PW   = NUMW + 32;

   // ceil(2^34 / 100) and ceil(2^40 / 1000), exact for numerators below 2^27
   localparam logic [31:0] RCP100  = 32'd171798692;
   localparam logic [31:0] RCP1000 = 32'd1099511628;
   localparam int          SH100   = 34;
   localparam int          SH1000  = 40;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DRAIN, S_PEND, S_DGO, S_DWAIT, S_OUT, S_DONE
   } state_type;

   state_type      state_ff;
   logic           sel_pass_ff;
   logic           vld_ff;
   logic [AW-1:0]  idx_ff;
   logic [TIME_W-1:0] now_ff;
   logic [TIME_W-1:0] age_ff;
   logic [CNT_W-1:0]  pmin_ff;
   logic [CW-1:0]  fill_ff;
   logic [CW-1:0]  n_ff;
   logic [SW-1:0]  sum_ff;
   logic [DUR_W-1:0] max_ff;
   logic [BIT_W-1:0] bit_ff;
   logic [CW-1:0]  rank_ff [4];
   logic [NUMW-1:0] num_ff [3];
   logic [DUR_W-1:0] pre_ff [4];
   logic [CW-1:0]  cnt_ff [4];
   logic [MEAN_W-1:0] mean_ff;
   wlp_result_type result_ff;

   logic [DUR_W-1:0]  rd_dur;
   logic [TIME_W-1:0] rd_done_at;
   logic              inwin;
   logic [DUR_W-1:0]  cand [4];
   logic              div_start;
   logic              div_done;
   logic [DW-1:0]     div_a;
   logic [VW-1:0]     div_b;
   logic [DW-1:0]     div_q;
   logic              p_valid;

   assign rd_dur     = mem_rdata[DUR_W-1:0];
   assign rd_done_at = mem_rdata[ENTRY_W-1:DUR_W];
   assign inwin      = (rd_done_at <= now_ff) && ((now_ff - rd_done_at) <= age_ff);
   assign p_valid    = 32'(n_ff) >= 32'(pmin_ff);

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         cand[j] = pre_ff[j] | (DUR_W'(1) << bit_ff);
      end
   end

   assign div_a     = {sum_ff, FRAC_W'(0)};
   assign div_b     = VW'(n_ff);
   assign div_start = state_ff == S_DGO;

   wlp_div #(.DW(DW), .VW(VW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         vld_ff <= state_ff == S_SCAN;
         if (vld_ff && inwin) begin
            if (!sel_pass_ff) begin
               n_ff   <= n_ff + 1'b1;
               sum_ff <= sum_ff + SW'(rd_dur);
               if (rd_dur > max_ff) begin
                  max_ff <= rd_dur;
               end
            end else begin
               for (int j = 0; j < 4; j++) begin
                  if (rd_dur < cand[j]) begin
                     cnt_ff[j] <= cnt_ff[j] + 1'b1;
                  end
               end
            end
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  now_ff      <= now_time;
                  age_ff      <= max_age;
                  pmin_ff     <= p999_min;
                  fill_ff     <= fill;
                  n_ff        <= '0;
                  sum_ff      <= '0;
                  max_ff      <= '0;
                  sel_pass_ff <= 1'b0;
                  idx_ff      <= '0;
                  if (fill == '0) begin
                     result_ff <= '0;
                     state_ff  <= S_DONE;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               if (CW'(idx_ff) + CW'(1) == fill_ff) begin
                  state_ff <= S_DRAIN;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_DRAIN: begin
               state_ff <= S_PEND;
            end
            S_PEND: begin
               if (!sel_pass_ff) begin
                  if (n_ff == '0) begin
                     result_ff <= '0;
                     state_ff  <= S_DONE;
                  end else begin
                     rank_ff[0] <= CW'((({1'b0, n_ff}) + 1'b1) >> 1);
                     num_ff[0]  <= NUMW'(n_ff) * NUMW'(95) + NUMW'(99);
                     num_ff[1]  <= NUMW'(n_ff) * NUMW'(99) + NUMW'(99);
                     num_ff[2]  <= NUMW'(n_ff) * NUMW'(999) + NUMW'(999);
                     state_ff   <= S_DGO;
                  end
               end else begin
                  for (int j = 0; j < 4; j++) begin
                     if (cnt_ff[j] < rank_ff[j]) begin
                        pre_ff[j] <= cand[j];
                     end
                     cnt_ff[j] <= '0;
                  end
                  if (bit_ff == '0) begin
                     state_ff <= S_OUT;
                  end else begin
                     bit_ff   <= bit_ff - 1'b1;
                     idx_ff   <= '0;
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_DGO: begin
               rank_ff[1] <= CW'((PW'(num_ff[0]) * PW'(RCP100)) >> SH100);
               rank_ff[2] <= CW'((PW'(num_ff[1]) * PW'(RCP100)) >> SH100);
               rank_ff[3] <= CW'((PW'(num_ff[2]) * PW'(RCP1000)) >> SH1000);
               state_ff   <= S_DWAIT;
            end
            S_DWAIT: begin
               if (div_done) begin
                  mean_ff     <= div_q[MEAN_W-1:0];
                  sel_pass_ff <= 1'b1;
                  bit_ff      <= BIT_W'(DUR_W - 1);
                  idx_ff      <= '0;
                  for (int j = 0; j < 4; j++) begin
                     pre_ff[j] <= '0;
                     cnt_ff[j] <= '0;
                  end
                  state_ff <= S_SCAN;
               end
            end
            S_OUT: begin
               result_ff.sample_count <= CNT_W'(n_ff);
               result_ff.mean_fixed   <= mean_ff;
               result_ff.median       <= pre_ff[0];
               result_ff.pct95        <= pre_ff[1];
               result_ff.pct99        <= pre_ff[2];
               result_ff.pct999       <= p_valid ? pre_ff[3] : '0;
               result_ff.largest      <= max_ff;
               result_ff.pct999_valid <= p_valid;
               state_ff               <= S_DONE;
            end
            S_DONE: begin
               if (take) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign mem_re    = state_ff == S_SCAN;
   assign mem_raddr = idx_ff;
   assign done      = state_ff == S_DONE;
   assign result    = result_ff;

endmodule

`default_nettype wire

// ===== sv/windowed_latency_percentiles_top.sv =====
// ----------------------------------------------------------------------------
// windowed_latency_percentiles_top
// Sliding-window latency monitor: records samples into a ring and answers
// queries with count, mean and nearest-rank percentiles.
// ----------------------------------------------------------------------------
// Record beats are taken one per clock while no query is in progress and give
// no response. A query beat holds req_tready low while it walks the ring: one
// summing pass, the three rank bounds by reciprocal products and one serial
// mean division, then 48 counting passes, one per duration bit, that select
// all four percentiles at once. Each pass reads one ring entry per cycle from
// the sample memory. The ring needs no clearing after reset; only written
// entries are ever read. A finished response waits in the output register
// while new records are accepted.
`default_nettype none

module windowed_latency_percentiles_top #(
   parameter int CAPACITY = wlp_pkg::DEF_CAPACITY,
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // duration[47:0], completed_at[111:48], now_time[175:112]
   input  wire logic [wlp_pkg::REQ_TDATA_W-1:0] req_tdata,
   // opcode
   input  wire logic                            req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // sample_count[10:0], mean_fixed[66:11], median[114:67], pct95[162:115],
   // pct99[210:163], pct999[258:211], largest[306:259], zero pad [311:307]
   output logic      [wlp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // pct999_valid
   output logic                                 rsp_tuser,
   input  wire logic                            csr_wen,
   input  wire logic                            csr_index,
   input  wire logic [wlp_pkg::TIME_W-1:0]      csr_wdata
);
   import wlp_pkg::*;

`include "windowed_latency_percentiles_top_defines.svh"

   logic [TIME_W-1:0] max_age_ff;
   logic [CNT_W-1:0]  pmin_ff;
   logic [AW-1:0]     wp_ff;
   logic [CW-1:0]     fill_ff;
   logic              busy_ff;
   logic              rsp_valid_ff;
   wlp_result_type    rsp_q_ff;

   logic              req_acc;
   logic              rec_acc;
   logic              qry_acc;
   logic              take;
   logic              q_done;
   wlp_result_type    q_result;
   logic              mem_re;
   logic [AW-1:0]     mem_raddr;
   logic [ENTRY_W-1:0] mem_rdata;

   assign req_tready = !busy_ff;
   assign req_acc    = req_tvalid && req_tready;
   assign rec_acc    = req_acc && (wlp_op_type'(req_tuser) == OP_RECORD);
   assign qry_acc    = req_acc && (wlp_op_type'(req_tuser) == OP_QUERY);
   assign take       = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff   <= MAX_AGE_RESET;
         pmin_ff      <= P999_RESET;
         wp_ff        <= '0;
         fill_ff      <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            case (wlp_csr_type'(csr_index))
               CSR_MAX_AGE:  max_age_ff <= (csr_wdata == '0) ? TIME_W'(1) : csr_wdata;
               CSR_P999_MIN: pmin_ff    <= csr_wdata[CNT_W-1:0];
               default:      pmin_ff    <= pmin_ff;
            endcase
         end
         if (rec_acc) begin
            wp_ff <= (wp_ff == AW'(CAPACITY - 1)) ? '0 : wp_ff + 1'b1;
            if (fill_ff != CW'(CAPACITY)) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end
         if (qry_acc) begin
            busy_ff <= 1'b1;
         end
         if (q_done && take) begin
            rsp_valid_ff <= 1'b1;
            rsp_q_ff     <= q_result;
            busy_ff      <= 1'b0;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   wlp_store #(.CAPACITY(CAPACITY)) u_store (
      .clock (clock),
      .we    (rec_acc),
      .waddr (wp_ff),
      .wdata ({req_tdata[DUR_W+TIME_W-1:DUR_W], req_tdata[DUR_W-1:0]}),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   wlp_query #(.CAPACITY(CAPACITY)) u_query (
      .clock     (clock),
      .reset     (reset),
      .start     (qry_acc),
      .now_time  (req_tdata[REQ_TDATA_W-1:DUR_W+TIME_W]),
      .max_age   (max_age_ff),
      .p999_min  (pmin_ff),
      .fill      (fill_ff),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata),
      .take      (take),
      .done      (q_done),
      .result    (q_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_q_ff.pct999_valid;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_q_ff.largest, rsp_q_ff.pct999, rsp_q_ff.pct99,
                                     rsp_q_ff.pct95, rsp_q_ff.median,
                                     rsp_q_ff.mean_fixed, rsp_q_ff.sample_count});

   `WLP_ASSERT_IMPL(a_fill_bound, clock, reset, 1'b1, fill_ff <= CW'(CAPACITY))
   `WLP_ASSERT_IMPL(a_done_busy, clock, reset, q_done, busy_ff)
   `WLP_ASSERT_NEXT(a_query_locks, clock, reset, qry_acc, busy_ff && !req_tready)

endmodule

`default_nettype wire
